FILE: src/etf_pkg.sv
// ----------------------------------------------------------------------------
// etf_pkg: shared definitions for the expression tokenizer
// Token kinds, operator and error codes, character constants and the result
// record that travels from the lexer core to the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

package etf_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;

  // Output queue; the lexer can make two results per request.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [3:0] KIND_NUMBER   = 4'd0;
  localparam logic [3:0] KIND_VARIABLE = 4'd1;
  localparam logic [3:0] KIND_FUNCTION = 4'd2;
  localparam logic [3:0] KIND_OPERATOR = 4'd3;
  localparam logic [3:0] KIND_LPAREN   = 4'd4;
  localparam logic [3:0] KIND_RPAREN   = 4'd5;
  localparam logic [3:0] KIND_COMMA    = 4'd6;
  localparam logic [3:0] KIND_END      = 4'd7;
  localparam logic [3:0] KIND_ERROR    = 4'd8;

  localparam logic [1:0] CONST_LITERAL = 2'd0;
  localparam logic [1:0] CONST_PI      = 2'd1;
  localparam logic [1:0] CONST_E       = 2'd2;

  localparam logic [2:0] OPC_PLUS   = 3'd0;
  localparam logic [2:0] OPC_MINUS  = 3'd1;
  localparam logic [2:0] OPC_TIMES  = 3'd2;
  localparam logic [2:0] OPC_DIVIDE = 3'd3;
  localparam logic [2:0] OPC_POWER  = 3'd4;

  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_BAD_NUMBER  = 2'd1;
  localparam logic [1:0] ERR_UNSUPPORTED = 2'd2;
  localparam logic [1:0] ERR_TOO_LONG    = 2'd3;

  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_CARET      = 8'h5E;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_LOWER_E    = 8'h65;
  localparam logic [7:0] CH_UPPER_E    = 8'h45;
  localparam logic [7:0] CH_LOWER_I    = 8'h69;
  localparam logic [7:0] CH_LOWER_P    = 8'h70;
  localparam logic [7:0] CH_LOWER_X    = 8'h78;

  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  named_constant;
    logic [2:0]  operator_code;
    logic [15:0] start_pos;
    logic [15:0] token_length;
    logic [1:0]  error_code;
    logic [7:0]  bad_character;
    logic        last;
  } etf_result_t;

  function automatic etf_result_t make_result(
    input logic [3:0]  kind,
    input logic [1:0]  named_constant,
    input logic [2:0]  operator_code,
    input logic [15:0] start_pos,
    input logic [15:0] token_length,
    input logic [1:0]  error_code,
    input logic [7:0]  bad_character
  );
    etf_result_t r;
    r.kind           = kind;
    r.named_constant = named_constant;
    r.operator_code  = operator_code;
    r.start_pos      = start_pos;
    r.token_length   = token_length;
    r.error_code     = error_code;
    r.bad_character  = bad_character;
    r.last           = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/expression_tokenizer_fsm.sv
// ----------------------------------------------------------------------------
// expression_tokenizer_fsm: streaming lexer for arithmetic expressions
// Turns a character stream into number, name, operator, paren, comma, end
// and error tokens with their start position and length.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one request per character (in_op = 0) and a
//   final request with in_op = 1 to mark the end of an expression. The
//   result channel carries tokens; out_last marks the last token caused by
//   a request. A request causes zero, one or two tokens.
//   Each accepted character is scanned in the cycle it is accepted and its
//   tokens enter a four-entry result queue, so the first token can be seen
//   on the output in the cycle after acceptance. One request is taken per
//   cycle as long as the queue has two free entries; with a receiver that
//   takes a token every cycle the block sustains one character per cycle.
//   Only requests that make two tokens (a delimiter closing a number or
//   name) can add to the queue backlog.
//   When the receiver stalls, queued tokens hold and in_ready drops once
//   fewer than two entries are free. Reset empties the queue and returns
//   the scanner to the idle state at position zero.
// ----------------------------------------------------------------------------
`default_nettype none

module expression_tokenizer_fsm #(
  parameter int POSITION_BITS = etf_pkg::POSITION_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_character,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_kind,
  output logic [1:0]       out_named_constant,
  output logic [2:0]       out_operator_code,
  output logic [15:0]      out_start_pos,
  output logic [15:0]      out_token_length,
  output logic [1:0]       out_error_code,
  output logic [7:0]       out_bad_character,
  output logic             out_last
);

  logic                 accept;
  logic                 room;
  logic [1:0]           push_cnt;
  etf_pkg::etf_result_t res0, res1, head;

  assign in_ready = room;
  assign accept   = in_valid && room;

  etf_lexer_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .op       (in_op),
    .character(in_character),
    .res0     (res0),
    .res1     (res1),
    .push_cnt (push_cnt)
  );

  etf_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push0    (res0),
    .push1    (res1),
    .push_cnt (push_cnt),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (head)
  );

  assign out_kind           = head.kind;
  assign out_named_constant = head.named_constant;
  assign out_operator_code  = head.operator_code;
  assign out_start_pos      = head.start_pos;
  assign out_token_length   = head.token_length;
  assign out_error_code     = head.error_code;
  assign out_bad_character  = head.bad_character;
  assign out_last           = head.last;

endmodule

`default_nettype wire

FILE: src/etf_lexer_core.sv
// ----------------------------------------------------------------------------
// etf_lexer_core: per-character scanning state machine
// Holds the scan state and position and, for each accepted request, works
// out in one step the next state and up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module etf_lexer_core #(
  parameter int POSITION_BITS = etf_pkg::POSITION_BITS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic                op,
  input  wire logic [7:0]          character,
  output etf_pkg::etf_result_t     res0,
  output etf_pkg::etf_result_t     res1,
  output logic [1:0]               push_cnt
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_ERROR
  } mode_t;

  localparam logic [2:0] NM_NONE = 3'd0;
  localparam logic [2:0] NM_X    = 3'd1;
  localparam logic [2:0] NM_P    = 3'd2;
  localparam logic [2:0] NM_PI   = 3'd3;
  localparam logic [2:0] NM_E    = 3'd4;

  localparam int XW = (POSITION_BITS > 16) ? POSITION_BITS : 16;

  mode_t                    mode_r, mode_nxt;
  logic                     seen_dot_r, seen_dot_nxt;
  logic                     seen_exp_r, seen_exp_nxt;
  logic                     seen_mant_r, seen_mant_nxt;
  logic                     sign_ok_r, sign_ok_nxt;
  logic [2:0]               name_match_r, name_match_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] tok_start_r, tok_start_nxt;

  logic [POSITION_BITS-1:0] tok_len;
  logic [XW-1:0]            pos_x, start_x, len_x;
  logic [15:0]              pos16, start16, len16;

  logic is_digit, is_alpha, is_space;
  logic num_cont, ident_cont;
  logic pend_valid, pend_bad;
  etf_pkg::etf_result_t pend_res;
  etf_pkg::etf_result_t res [2];
  logic [1:0] cnt;
  logic       dispatch;

  assign is_digit = (character inside {[8'h30:8'h39]});
  assign is_alpha = (character inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  assign is_space = (character == etf_pkg::CH_SPACE) || (character inside {[8'h09:8'h0D]});

  assign tok_len = pos_r - tok_start_r;
  assign pos_x   = XW'(pos_r);
  assign start_x = XW'(tok_start_r);
  assign len_x   = XW'(tok_len);
  assign pos16   = pos_x[15:0];
  assign start16 = start_x[15:0];
  assign len16   = len_x[15:0];

  // Whether the current character extends the token in progress.
  assign num_cont = is_digit
                 || ((character == etf_pkg::CH_DOT) && !seen_dot_r && !seen_exp_r)
                 || (((character == etf_pkg::CH_LOWER_E) || (character == etf_pkg::CH_UPPER_E))
                     && !seen_exp_r)
                 || (((character == etf_pkg::CH_PLUS) || (character == etf_pkg::CH_MINUS))
                     && sign_ok_r);
  assign ident_cont = is_alpha || is_digit || (character == etf_pkg::CH_UNDERSCORE);

  // The token that a closing character or the end marker would emit.
  always_comb begin
    pend_valid = (mode_r == MODE_NUMBER) || (mode_r == MODE_IDENT);
    pend_bad   = (mode_r == MODE_NUMBER) && !seen_mant_r;
    pend_res   = etf_pkg::make_result(etf_pkg::KIND_FUNCTION, etf_pkg::CONST_LITERAL,
                                      etf_pkg::OPC_PLUS, start16, len16,
                                      etf_pkg::ERR_NONE, 8'h00);
    if (mode_r == MODE_NUMBER) begin
      if (!seen_mant_r) begin
        pend_res.kind       = etf_pkg::KIND_ERROR;
        pend_res.error_code = etf_pkg::ERR_BAD_NUMBER;
      end else begin
        pend_res.kind = etf_pkg::KIND_NUMBER;
      end
    end else begin
      case (name_match_r)
        NM_X:    pend_res.kind = etf_pkg::KIND_VARIABLE;
        NM_PI: begin
          pend_res.kind           = etf_pkg::KIND_NUMBER;
          pend_res.named_constant = etf_pkg::CONST_PI;
        end
        NM_E: begin
          pend_res.kind           = etf_pkg::KIND_NUMBER;
          pend_res.named_constant = etf_pkg::CONST_E;
        end
        default: pend_res.kind = etf_pkg::KIND_FUNCTION;
      endcase
    end
  end

  always_comb begin
    mode_nxt       = mode_r;
    seen_dot_nxt   = seen_dot_r;
    seen_exp_nxt   = seen_exp_r;
    seen_mant_nxt  = seen_mant_r;
    sign_ok_nxt    = sign_ok_r;
    name_match_nxt = name_match_r;
    pos_nxt        = pos_r;
    tok_start_nxt  = tok_start_r;
    res[0]         = '0;
    res[1]         = '0;
    cnt            = 2'd0;
    dispatch       = 1'b0;

    if (accept) begin
      if (op == etf_pkg::OP_END) begin
        if (mode_r != MODE_ERROR) begin
          if (pend_valid) begin
            res[0] = pend_res;
            cnt    = 2'd1;
          end
          if (!pend_bad) begin
            res[cnt[0]] = etf_pkg::make_result(etf_pkg::KIND_END, etf_pkg::CONST_LITERAL,
                                               etf_pkg::OPC_PLUS, pos16, 16'd0,
                                               etf_pkg::ERR_NONE, 8'h00);
            cnt = cnt + 2'd1;
          end
        end
        mode_nxt       = MODE_IDLE;
        seen_dot_nxt   = 1'b0;
        seen_exp_nxt   = 1'b0;
        seen_mant_nxt  = 1'b0;
        sign_ok_nxt    = 1'b0;
        name_match_nxt = NM_NONE;
        pos_nxt        = '0;
        tok_start_nxt  = '0;
      end else if (mode_r != MODE_ERROR) begin
        if (&pos_r) begin
          res[0]   = etf_pkg::make_result(etf_pkg::KIND_ERROR, etf_pkg::CONST_LITERAL,
                                          etf_pkg::OPC_PLUS, pos16, 16'd0,
                                          etf_pkg::ERR_TOO_LONG, 8'h00);
          cnt      = 2'd1;
          mode_nxt = MODE_ERROR;
        end else begin
          dispatch = 1'b1;
          pos_nxt  = pos_r + 1'b1;
          if ((mode_r == MODE_NUMBER) && num_cont) begin
            dispatch    = 1'b0;
            sign_ok_nxt = 1'b0;
            if (is_digit) begin
              if (!seen_exp_r) begin
                seen_mant_nxt = 1'b1;
              end
            end else if (character == etf_pkg::CH_DOT) begin
              seen_dot_nxt = 1'b1;
            end else if ((character == etf_pkg::CH_LOWER_E)
                         || (character == etf_pkg::CH_UPPER_E)) begin
              seen_exp_nxt = 1'b1;
              sign_ok_nxt  = 1'b1;
            end
          end else if ((mode_r == MODE_IDENT) && ident_cont) begin
            dispatch       = 1'b0;
            name_match_nxt = ((name_match_r == NM_P) && (character == etf_pkg::CH_LOWER_I))
                             ? NM_PI : NM_NONE;
          end else if (pend_valid) begin
            res[0] = pend_res;
            cnt    = 2'd1;
            if (pend_bad) begin
              // An invalid number swallows its closing character.
              dispatch = 1'b0;
              mode_nxt = MODE_ERROR;
              pos_nxt  = pos_r;
            end
          end

          if (dispatch) begin
            mode_nxt       = MODE_IDLE;
            seen_dot_nxt   = 1'b0;
            seen_exp_nxt   = 1'b0;
            seen_mant_nxt  = 1'b0;
            sign_ok_nxt    = 1'b0;
            name_match_nxt = NM_NONE;
            if (is_space) begin
              mode_nxt = MODE_IDLE;
            end else if (is_digit || (character == etf_pkg::CH_DOT)) begin
              mode_nxt      = MODE_NUMBER;
              seen_dot_nxt  = (character == etf_pkg::CH_DOT);
              seen_mant_nxt = is_digit;
              tok_start_nxt = pos_r;
            end else if (is_alpha) begin
              mode_nxt      = MODE_IDENT;
              tok_start_nxt = pos_r;
              case (character)
                etf_pkg::CH_LOWER_X: name_match_nxt = NM_X;
                etf_pkg::CH_LOWER_P: name_match_nxt = NM_P;
                etf_pkg::CH_LOWER_E: name_match_nxt = NM_E;
                default:             name_match_nxt = NM_NONE;
              endcase
            end else begin
              res[cnt[0]] = etf_pkg::make_result(etf_pkg::KIND_OPERATOR, etf_pkg::CONST_LITERAL,
                                                 etf_pkg::OPC_PLUS, pos16, 16'd1,
                                                 etf_pkg::ERR_NONE, 8'h00);
              cnt = cnt + 2'd1;
              case (character)
                etf_pkg::CH_PLUS:   res[cnt[0] ^ 1'b1].operator_code = etf_pkg::OPC_PLUS;
                etf_pkg::CH_MINUS:  res[cnt[0] ^ 1'b1].operator_code = etf_pkg::OPC_MINUS;
                etf_pkg::CH_STAR:   res[cnt[0] ^ 1'b1].operator_code = etf_pkg::OPC_TIMES;
                etf_pkg::CH_SLASH:  res[cnt[0] ^ 1'b1].operator_code = etf_pkg::OPC_DIVIDE;
                etf_pkg::CH_CARET:  res[cnt[0] ^ 1'b1].operator_code = etf_pkg::OPC_POWER;
                etf_pkg::CH_LPAREN: res[cnt[0] ^ 1'b1].kind = etf_pkg::KIND_LPAREN;
                etf_pkg::CH_RPAREN: res[cnt[0] ^ 1'b1].kind = etf_pkg::KIND_RPAREN;
                etf_pkg::CH_COMMA:  res[cnt[0] ^ 1'b1].kind = etf_pkg::KIND_COMMA;
                default: begin
                  res[cnt[0] ^ 1'b1].kind          = etf_pkg::KIND_ERROR;
                  res[cnt[0] ^ 1'b1].error_code    = etf_pkg::ERR_UNSUPPORTED;
                  res[cnt[0] ^ 1'b1].bad_character = character;
                  mode_nxt = MODE_ERROR;
                end
              endcase
            end
          end
        end
      end
    end

    if (cnt != 2'd0) begin
      res[cnt[0] ^ 1'b1].last = 1'b1;
    end
  end

  // cnt is 1 or 2 when nonzero, so slot (cnt[0] ^ 1) is the last one written.
  assign res0     = res[0];
  assign res1     = res[1];
  assign push_cnt = cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      seen_dot_r   <= 1'b0;
      seen_exp_r   <= 1'b0;
      seen_mant_r  <= 1'b0;
      sign_ok_r    <= 1'b0;
      name_match_r <= NM_NONE;
      pos_r        <= '0;
      tok_start_r  <= '0;
    end else begin
      mode_r       <= mode_nxt;
      seen_dot_r   <= seen_dot_nxt;
      seen_exp_r   <= seen_exp_nxt;
      seen_mant_r  <= seen_mant_nxt;
      sign_ok_r    <= sign_ok_nxt;
      name_match_r <= name_match_nxt;
      pos_r        <= pos_nxt;
      tok_start_r  <= tok_start_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/etf_out_queue.sv
// ----------------------------------------------------------------------------
// etf_out_queue: result queue between the lexer core and the output channel
// Takes zero, one or two results per cycle and hands them out one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module etf_out_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire etf_pkg::etf_result_t push0,
  input  wire etf_pkg::etf_result_t push1,
  input  wire logic [1:0]           push_cnt,
  output logic                      room,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output etf_pkg::etf_result_t      out_res
);

  localparam int PW = etf_pkg::QUEUE_PTR_BITS;

  etf_pkg::etf_result_t entry_r [etf_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          pop;
  logic [PW-1:0] wr_ptr_p1;

  // Two free entries are needed because one request can make two results.
  assign room      = (count_r <= (PW+1)'(etf_pkg::QUEUE_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_res   = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push_cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PW+1)'(push_cnt) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      entry_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      entry_r[wr_ptr_p1] <= push1;
    end
  end

endmodule

`default_nettype wire

FILE: src/etf_checker.sv
// ----------------------------------------------------------------------------
// etf_checker: port-level checks for the expression tokenizer
// Watches the result channel for stalls and for consistent token fields.
// ----------------------------------------------------------------------------
`default_nettype none

module etf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_kind,
  input wire logic [1:0]  out_named_constant,
  input wire logic [15:0] out_token_length,
  input wire logic [1:0]  out_error_code,
  input wire logic [7:0]  out_bad_character,
  input wire logic        out_last
);

  // A stalled token must stay on the output.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind))
    else $error("result dropped while stalled");

  // The end token always closes its request and has no length.
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == etf_pkg::KIND_END) |-> out_last && (out_token_length == 16'd0))
    else $error("malformed end token");

  // Errors always end a request and carry a code.
  a_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == etf_pkg::KIND_ERROR)
      |-> out_last && (out_error_code != etf_pkg::ERR_NONE))
    else $error("malformed error token");

  // Normal tokens carry no error information.
  a_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != etf_pkg::KIND_ERROR)
      |-> (out_error_code == etf_pkg::ERR_NONE) && (out_bad_character == 8'h00))
    else $error("error fields set on a normal token");

  // Only number tokens name a constant.
  a_named: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != etf_pkg::KIND_NUMBER)
      |-> (out_named_constant == etf_pkg::CONST_LITERAL))
    else $error("named constant on a non-number token");

endmodule

bind expression_tokenizer_fsm etf_checker u_etf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_kind          (out_kind),
  .out_named_constant(out_named_constant),
  .out_token_length  (out_token_length),
  .out_error_code    (out_error_code),
  .out_bad_character (out_bad_character),
  .out_last          (out_last)
);

`default_nettype wire

FILE: tb/tb_expression_tokenizer_fsm.sv
// ----------------------------------------------------------------------------
// tb_expression_tokenizer_fsm: self-checking testbench for the expression lexer
// A short table of directed requests, then random expressions built from
// well-formed tokens with some noise. A behavioral scanner predicts the
// tokens of each accepted request unless typed in by hand; each token out
// of the block is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_expression_tokenizer_fsm;
  import etf_pkg::*;

  localparam int unsigned POS_MAX = (32'd1 << POSITION_BITS_DEFAULT) - 1;
  localparam int RANDOM_ITEMS = 920;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_TOP     = 8'hFF;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUMBER, SCAN_NAME, SCAN_ERROR} scan_state_t;
  typedef enum logic [2:0] {PREFIX_NONE, PREFIX_X, PREFIX_P, PREFIX_PI, PREFIX_E} prefix_t;

  typedef struct {
    logic        op;
    logic [7:0]  ch;
    bit          typed;
    etf_result_t want;
  } request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_op = OP_CHAR;
  logic [7:0]  in_character = CH_NUL;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [3:0]  out_kind;
  logic [1:0]  out_named_constant;
  logic [2:0]  out_operator_code;
  logic [15:0] out_start_pos;
  logic [15:0] out_token_length;
  logic [1:0]  out_error_code;
  logic [7:0]  out_bad_character;
  logic        out_last;

  expression_tokenizer_fsm uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_character       (in_character),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_named_constant (out_named_constant),
    .out_operator_code  (out_operator_code),
    .out_start_pos      (out_start_pos),
    .out_token_length   (out_token_length),
    .out_error_code     (out_error_code),
    .out_bad_character  (out_bad_character),
    .out_last           (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int send_idle_pct = 25;
  int recv_idle_pct = 71;
  int mismatches = 0;
  int quiet_cycles = 0;
  int live_requests = 0;

  etf_result_t expected_tokens[$];
  etf_result_t step_tokens[$];
  request_t    plan[$];
  etf_result_t want;

  // Scanner state of the prediction.
  scan_state_t scan_state = SCAN_IDLE;
  prefix_t     name_prefix = PREFIX_NONE;
  bit          dot_taken, exp_taken, has_mantissa, sign_open;
  int unsigned char_pos = 0;
  int unsigned tok_start = 0;

  function automatic etf_result_t make_token(input logic [3:0] kind, input logic [1:0] named,
                                             input logic [2:0] opc, input int unsigned start,
                                             input int unsigned len, input logic [1:0] err,
                                             input logic [7:0] bad);
    etf_result_t t;
    t.kind           = kind;
    t.named_constant = named;
    t.operator_code  = opc;
    t.start_pos      = 16'(start);
    t.token_length   = 16'(len);
    t.error_code     = err;
    t.bad_character  = bad;
    t.last           = 1'b0;
    return t;
  endfunction

  function automatic void add_token(input logic [3:0] kind, input logic [1:0] named,
                                    input logic [2:0] opc, input int unsigned start,
                                    input int unsigned len, input logic [1:0] err,
                                    input logic [7:0] bad);
    step_tokens.insert(step_tokens.size(), make_token(kind, named, opc, start, len, err, bad));
  endfunction

  function automatic bit digit_char(input logic [7:0] c);
    return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
  endfunction

  function automatic bit letter_char(input logic [7:0] c);
    return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void clear_flags();
    dot_taken    = 1'b0;
    exp_taken    = 1'b0;
    has_mantissa = 1'b0;
    sign_open    = 1'b0;
    name_prefix  = PREFIX_NONE;
  endfunction

  function automatic void reset_scan();
    scan_state = SCAN_IDLE;
    clear_flags();
    char_pos  = 0;
    tok_start = 0;
  endfunction

  // Emits the number or name in progress; returns 0 for a number without
  // any mantissa digit, which becomes an error token instead.
  function automatic bit close_token();
    int unsigned len;
    len = (char_pos - tok_start) & POS_MAX;
    if (scan_state == SCAN_NUMBER) begin
      if (!has_mantissa) begin
        add_token(KIND_ERROR, CONST_LITERAL, '0, tok_start, len, ERR_BAD_NUMBER, '0);
        return 1'b0;
      end
      add_token(KIND_NUMBER, CONST_LITERAL, '0, tok_start, len, ERR_NONE, '0);
    end else if (scan_state == SCAN_NAME) begin
      case (name_prefix)
        PREFIX_X:  add_token(KIND_VARIABLE, CONST_LITERAL, '0, tok_start, len, ERR_NONE, '0);
        PREFIX_PI: add_token(KIND_NUMBER, CONST_PI, '0, tok_start, len, ERR_NONE, '0);
        PREFIX_E:  add_token(KIND_NUMBER, CONST_E, '0, tok_start, len, ERR_NONE, '0);
        default:   add_token(KIND_FUNCTION, CONST_LITERAL, '0, tok_start, len, ERR_NONE, '0);
      endcase
    end
    scan_state = SCAN_IDLE;
    clear_flags();
    return 1'b1;
  endfunction

  function automatic bit number_grows(input logic [7:0] c);
    bit sign_was_open;
    sign_was_open = sign_open;
    sign_open = 1'b0;
    if (digit_char(c)) begin
      if (!exp_taken) has_mantissa = 1'b1;
      return 1'b1;
    end
    if (c == CH_DOT && !dot_taken && !exp_taken) begin
      dot_taken = 1'b1;
      return 1'b1;
    end
    if ((c == CH_LOWER_E || c == CH_UPPER_E) && !exp_taken) begin
      exp_taken = 1'b1;
      sign_open = 1'b1;
      return 1'b1;
    end
    return (c == CH_PLUS || c == CH_MINUS) && sign_was_open;
  endfunction

  // Works out the tokens that one request causes, into step_tokens.
  function automatic void tokenize_char(input logic op, input logic [7:0] c);
    bit consumed;
    consumed = 1'b0;
    step_tokens.delete();
    if (op == OP_END) begin
      if (scan_state != SCAN_ERROR) begin
        if (close_token())
          add_token(KIND_END, CONST_LITERAL, '0, char_pos, 0, ERR_NONE, '0);
      end
      reset_scan();
    end else if (scan_state != SCAN_ERROR) begin
      if (char_pos >= POS_MAX) begin
        // Position counter exhausted: any token in progress is lost.
        add_token(KIND_ERROR, CONST_LITERAL, '0, char_pos, 0, ERR_TOO_LONG, '0);
        scan_state = SCAN_ERROR;
        consumed = 1'b1;
      end else if (scan_state == SCAN_NUMBER) begin
        if (number_grows(c)) begin
          char_pos = (char_pos + 1) & POS_MAX;
          consumed = 1'b1;
        end else if (!close_token()) begin
          // A bad number swallows the character that closed it.
          scan_state = SCAN_ERROR;
          consumed = 1'b1;
        end
      end else if (scan_state == SCAN_NAME) begin
        if (letter_char(c) || digit_char(c) || c == CH_UNDERSCORE) begin
          if (name_prefix == PREFIX_P && c == CH_LOWER_I) name_prefix = PREFIX_PI;
          else name_prefix = PREFIX_NONE;
          char_pos = (char_pos + 1) & POS_MAX;
          consumed = 1'b1;
        end else begin
          void'(close_token());
        end
      end
      if (!consumed) begin
        if (digit_char(c) || c == CH_DOT) begin
          clear_flags();
          scan_state   = SCAN_NUMBER;
          dot_taken    = (c == CH_DOT);
          has_mantissa = digit_char(c);
          tok_start    = char_pos;
        end else if (letter_char(c)) begin
          clear_flags();
          scan_state = SCAN_NAME;
          case (c)
            CH_LOWER_X: name_prefix = PREFIX_X;
            CH_LOWER_P: name_prefix = PREFIX_P;
            CH_LOWER_E: name_prefix = PREFIX_E;
            default:    name_prefix = PREFIX_NONE;
          endcase
          tok_start = char_pos;
        end else if (!blank_char(c)) begin
          case (c)
            CH_PLUS:   add_token(KIND_OPERATOR, CONST_LITERAL, OPC_PLUS, char_pos, 1, ERR_NONE, '0);
            CH_MINUS:  add_token(KIND_OPERATOR, CONST_LITERAL, OPC_MINUS, char_pos, 1, ERR_NONE, '0);
            CH_STAR:   add_token(KIND_OPERATOR, CONST_LITERAL, OPC_TIMES, char_pos, 1, ERR_NONE, '0);
            CH_SLASH:  add_token(KIND_OPERATOR, CONST_LITERAL, OPC_DIVIDE, char_pos, 1, ERR_NONE,
                                 '0);
            CH_CARET:  add_token(KIND_OPERATOR, CONST_LITERAL, OPC_POWER, char_pos, 1, ERR_NONE, '0);
            CH_LPAREN: add_token(KIND_LPAREN, CONST_LITERAL, '0, char_pos, 1, ERR_NONE, '0);
            CH_RPAREN: add_token(KIND_RPAREN, CONST_LITERAL, '0, char_pos, 1, ERR_NONE, '0);
            CH_COMMA:  add_token(KIND_COMMA, CONST_LITERAL, '0, char_pos, 1, ERR_NONE, '0);
            default: begin
              add_token(KIND_ERROR, CONST_LITERAL, '0, char_pos, 1, ERR_UNSUPPORTED, c);
              scan_state = SCAN_ERROR;
            end
          endcase
        end
        char_pos = (char_pos + 1) & POS_MAX;
      end
    end
    if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
  endfunction

  function automatic void add_item(input logic op, input logic [7:0] ch, input bit typed,
                                   input etf_result_t tok);
    request_t r;
    r.op    = op;
    r.ch    = ch;
    r.typed = typed;
    r.want  = tok;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void add_char(input logic [7:0] ch);
    add_item(OP_CHAR, ch, 1'b0, '0);
  endfunction

  // A request whose single token is typed in by hand.
  function automatic void add_typed(input logic op, input logic [7:0] ch, input logic [3:0] kind,
                                    input int unsigned start, input int unsigned len,
                                    input logic [1:0] err, input logic [7:0] bad);
    etf_result_t t;
    t = make_token(kind, CONST_LITERAL, '0, start, len, err, bad);
    t.last = 1'b1;
    add_item(op, ch, 1'b1, t);
  endfunction

  function automatic void add_digits(input int lo, input int hi);
    repeat ($urandom_range(hi, lo)) add_char(8'(CH_DIGIT_0 + $urandom_range(9)));
  endfunction

  function automatic void add_number();
    if ($urandom_range(3) == 0) begin
      add_char(CH_DOT);
      add_digits(1, 3);
    end else begin
      add_digits(1, 3);
      if ($urandom_range(1) == 1) begin
        add_char(CH_DOT);
        add_digits(0, 2);
      end
    end
    if ($urandom_range(2) == 0) begin
      add_char($urandom_range(1) == 1 ? CH_LOWER_E : CH_UPPER_E);
      case ($urandom_range(2))
        0:       add_char(CH_PLUS);
        1:       add_char(CH_MINUS);
        default: ;
      endcase
      add_digits(0, 2);
    end
  endfunction

  function automatic void add_name();
    case ($urandom_range(5))
      0: add_char(CH_LOWER_X);
      1: begin
        add_char(CH_LOWER_P);
        add_char(CH_LOWER_I);
      end
      2: add_char(CH_LOWER_E);
      3: add_char(CH_LOWER_P);
      default: begin
        if ($urandom_range(1) == 1) add_char(8'(CH_LOWER_A + $urandom_range(25)));
        else add_char(8'(CH_UPPER_A + $urandom_range(25)));
      end
    endcase
    repeat ($urandom_range(3)) begin
      case ($urandom_range(3))
        0:       add_char(8'(CH_LOWER_A + $urandom_range(25)));
        1:       add_char(8'(CH_UPPER_A + $urandom_range(25)));
        2:       add_char(8'(CH_DIGIT_0 + $urandom_range(9)));
        default: add_char(CH_UNDERSCORE);
      endcase
    end
  endfunction

  // One random expression: mostly sensible tokens, some broken numbers and
  // some arbitrary bytes, closed by an end request.
  function automatic void build_expression();
    repeat ($urandom_range(10, 1)) begin
      case ($urandom_range(15))
        0, 1, 2, 3: add_number();
        4, 5, 6:    add_name();
        7, 8, 9: begin
          case ($urandom_range(4))
            0:       add_char(CH_PLUS);
            1:       add_char(CH_MINUS);
            2:       add_char(CH_STAR);
            3:       add_char(CH_SLASH);
            default: add_char(CH_CARET);
          endcase
        end
        10: add_char($urandom_range(1) == 1 ? CH_LPAREN : CH_RPAREN);
        11: add_char(CH_COMMA);
        12: repeat ($urandom_range(3, 1)) add_char(8'(CH_TAB + $urandom_range(4)));
        13: begin
          add_char(CH_DOT);
          if ($urandom_range(1) == 1) add_char($urandom_range(1) == 1 ? CH_LOWER_E : CH_UPPER_E);
        end
        14:      add_char(8'($urandom_range(255)));
        default: add_char(CH_SPACE);
      endcase
      if ($urandom_range(1) == 1) add_char(CH_SPACE);
    end
    add_item(OP_END, 8'($urandom_range(255)), 1'b0, '0);
  endfunction

  task automatic send_request(input request_t r);
    bit taken;
    taken = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= r.op;
    in_character <= r.ch;
    // Handshake is judged at the falling edge, where every signal is settled.
    while (!taken) begin
      @(negedge clk);
      if (in_ready) begin
        taken = 1'b1;
        live_requests++;
        tokenize_char(r.op, r.ch);
        if (r.typed) expected_tokens.insert(expected_tokens.size(), r.want);
        else foreach (step_tokens[k]) expected_tokens.insert(expected_tokens.size(),
                                                             step_tokens[k]);
      end
      @(posedge clk);
    end
  endtask

  task automatic run_plan();
    while (plan.size() != 0) send_request(plan.pop_front());
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic check_field(input string field, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: token with nothing expected, expected none, actual kind %0d at %0d",
                   $time, out_kind, out_start_pos);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("named_constant", want.named_constant, out_named_constant);
          check_field("operator_code", want.operator_code, out_operator_code);
          check_field("start_pos", want.start_pos, out_start_pos);
          check_field("token_length", want.token_length, out_token_length);
          check_field("error_code", want.error_code, out_error_code);
          check_field("bad_character", want.bad_character, out_bad_character);
          check_field("last", want.last, out_last);
        end
      end
    end
  end

  initial begin
    wait (rst_n);
    while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    reset_scan();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every token kind, constants, exponent with sign, then the
    // bad-number and unsupported-character errors and an empty expression.
    add_char(CH_LOWER_P);
    add_char(CH_LOWER_I);
    add_char(CH_STAR);
    add_char(CH_LOWER_X);
    add_char(CH_CARET);
    add_char(8'(CH_DIGIT_0 + 1));
    add_char(CH_DOT);
    add_char(CH_UPPER_E);
    add_char(CH_MINUS);
    add_char(8'(CH_DIGIT_0 + 7));
    add_char(CH_RPAREN);
    add_char(CH_SPACE);
    add_char(CH_LOWER_E);
    add_char(CH_COMMA);
    add_char(CH_LPAREN);
    add_char(CH_SLASH);
    add_typed(OP_END, CH_TOP, KIND_END, 16, 0, ERR_NONE, '0);
    add_char(CH_DOT);
    add_typed(OP_CHAR, CH_COMMA, KIND_ERROR, 0, 1, ERR_BAD_NUMBER, '0);
    add_char(CH_PLUS);
    add_item(OP_END, CH_NUL, 1'b0, '0);
    add_char(CH_LOWER_A);
    add_char(CH_UNDERSCORE);
    add_char(CH_NUL);
    add_item(OP_END, CH_NUL, 1'b0, '0);
    add_typed(OP_CHAR, CH_TOP, KIND_ERROR, 0, 1, ERR_UNSUPPORTED, CH_TOP);
    add_item(OP_END, CH_NUL, 1'b0, '0);
    add_typed(OP_END, CH_NUL, KIND_END, 0, 0, ERR_NONE, '0);
    run_plan();

    live_requests = 0;
    while (live_requests < RANDOM_ITEMS) begin
      if (live_requests >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (live_requests >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 71;
        recv_idle_pct = 25;
      end
      build_expression();
      run_plan();
    end

    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/etf_pkg.sv
src/etf_lexer_core.sv
src/etf_out_queue.sv
src/expression_tokenizer_fsm.sv
src/etf_checker.sv
tb/tb_expression_tokenizer_fsm.sv
